// ===== src/tdg_pkg.sv =====
// Shared widths, payload structs and saturation helper for the triangle
// deformation gradient pipeline. No dependencies.
`default_nettype none
package tdg_pkg;

   // fixed-point format of coordinates, displacements and F
   localparam int FRAC_BITS = 16;
   localparam int CW        = 32;            // field width
   localparam int JW        = CW + 1;        // edge / displacement difference
   localparam int PRW       = 2 * JW;        // signed product
   localparam int XW        = PRW + 1;       // signed cross difference
   localparam int MW        = PRW;           // cross magnitude
   localparam int QB        = CW + 1;        // quotient bits kept
   localparam int RW        = MW + QB + 1;   // divider compare width
   localparam int DIV_LAT   = QB + 1;        // divider register stages
   localparam int SW        = QB + 3;        // signed sum before saturation
   localparam int AW        = 63;            // area width
   localparam int LANES     = 4;             // xx, xy, yx, yy

   localparam logic [SW-1:0] ONE_Q = SW'(1) << FRAC_BITS;

   // data that bypasses the dividers
   typedef struct packed {
      logic [LANES-1:0]         neg;
      logic                     degen;
      logic [AW-1:0]            area;
      logic [LANES-1:0][JW-1:0] disp;
   } side_type;

   // front end result for one triangle
   typedef struct packed {
      logic [LANES-1:0][MW-1:0] num_mag;
      logic [MW-1:0]            det_mag;
      side_type                 side;
   } front_type;

   // clamp a signed sum to the CW-bit signed range
   function automatic logic [CW-1:0] sat_word(input logic [SW-1:0] v);
      logic [CW-1:0] r;
      if (!v[SW-1] && (|v[SW-2:CW-1]))
         r = {1'b0, {(CW-1){1'b1}}};
      else if (v[SW-1] && !(&v[SW-2:CW-1]))
         r = {1'b1, {(CW-1){1'b0}}};
      else
         r = v[CW-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/tdg_front.sv =====
// Front end: edge differences, products, cross sums, magnitudes, degenerate
// test and area, three register stages. Depends on tdg_pkg.
`default_nettype none
module tdg_front
   import tdg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [CW-1:0] n0x,
   input  wire logic [CW-1:0] n0y,
   input  wire logic [CW-1:0] n1x,
   input  wire logic [CW-1:0] n1y,
   input  wire logic [CW-1:0] n2x,
   input  wire logic [CW-1:0] n2y,
   input  wire logic [CW-1:0] u0x,
   input  wire logic [CW-1:0] u0y,
   input  wire logic [CW-1:0] u1x,
   input  wire logic [CW-1:0] u1y,
   input  wire logic [CW-1:0] u2x,
   input  wire logic [CW-1:0] u2y,
   input  wire logic [CW-1:0] threshold,
   output logic               out_valid,
   output front_type          out_data
);

   logic [2:0] vld_ff;

   // stage 1: Jacobian entries and relative displacements (lane order)
   logic signed [JW-1:0] j00_ff, j10_ff, j01_ff, j11_ff;
   logic signed [JW-1:0] d1_ff [LANES];

   // stage 2: products
   logic signed [PRW-1:0] da_ff, db_ff;
   logic signed [PRW-1:0] pa_ff [LANES];
   logic signed [PRW-1:0] pb_ff [LANES];
   logic signed [JW-1:0]  d2_ff [LANES];

   // stage 3
   front_type out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      j00_ff   <= $signed({n1x[CW-1], n1x}) - $signed({n0x[CW-1], n0x});
      j10_ff   <= $signed({n1y[CW-1], n1y}) - $signed({n0y[CW-1], n0y});
      j01_ff   <= $signed({n2x[CW-1], n2x}) - $signed({n0x[CW-1], n0x});
      j11_ff   <= $signed({n2y[CW-1], n2y}) - $signed({n0y[CW-1], n0y});
      d1_ff[0] <= $signed({u1x[CW-1], u1x}) - $signed({u0x[CW-1], u0x});
      d1_ff[1] <= $signed({u2x[CW-1], u2x}) - $signed({u0x[CW-1], u0x});
      d1_ff[2] <= $signed({u1y[CW-1], u1y}) - $signed({u0y[CW-1], u0y});
      d1_ff[3] <= $signed({u2y[CW-1], u2y}) - $signed({u0y[CW-1], u0y});
   end

   // numerators: xx = d1x*J11 - d2x*J10, xy = d2x*J00 - d1x*J01, same for y
   always_ff @(posedge clock) begin
      da_ff    <= j00_ff * j11_ff;
      db_ff    <= j01_ff * j10_ff;
      pa_ff[0] <= d1_ff[0] * j11_ff;
      pb_ff[0] <= d1_ff[1] * j10_ff;
      pa_ff[1] <= d1_ff[1] * j00_ff;
      pb_ff[1] <= d1_ff[0] * j01_ff;
      pa_ff[2] <= d1_ff[2] * j11_ff;
      pb_ff[2] <= d1_ff[3] * j10_ff;
      pa_ff[3] <= d1_ff[3] * j00_ff;
      pb_ff[3] <= d1_ff[2] * j01_ff;
      for (int i = 0; i < LANES; i++) begin
         d2_ff[i] <= d1_ff[i];
      end
   end

   // cross sums, sign and magnitude, degenerate test, area
   always_comb begin
      logic signed [XW-1:0] det;
      logic signed [XW-1:0] cx;
      logic [XW-1:0]        ng;
      logic                 det_neg;
      det = $signed({da_ff[PRW-1], da_ff}) - $signed({db_ff[PRW-1], db_ff});
      det_neg = det[XW-1];
      ng = -det;
      out_in.det_mag = det_neg ? ng[MW-1:0] : det[MW-1:0];
      for (int i = 0; i < LANES; i++) begin
         cx = $signed({pa_ff[i][PRW-1], pa_ff[i]}) - $signed({pb_ff[i][PRW-1], pb_ff[i]});
         ng = -cx;
         out_in.num_mag[i]  = cx[XW-1] ? ng[MW-1:0] : cx[MW-1:0];
         out_in.side.neg[i] = cx[XW-1] ^ det_neg;
         out_in.side.disp[i] = d2_ff[i];
      end
      out_in.side.degen = (out_in.det_mag[MW-1:CW] == '0) &&
                          (out_in.det_mag[CW-1:0] <= threshold);
      if (out_in.det_mag[MW-1:AW+1] != '0)
         out_in.side.area = {AW{1'b1}};
      else
         out_in.side.area = out_in.det_mag[AW:1];
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = vld_ff[2];
   assign out_data  = out_ff;

endmodule
`default_nettype wire

// ===== src/tdg_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, overflow test in
// the first stage. Computes floor(num * 2^FRAC_BITS / den). Depends on tdg_pkg.
`default_nettype none
module tdg_divider
   import tdg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic [MW-1:0] num_mag,
   input  wire logic [MW-1:0] den_mag,
   output logic [QB-1:0]      quo,
   output logic               big
);

   logic [RW-1:0] rem_ff [0:QB-1];
   logic [MW-1:0] den_ff [0:QB-1];
   logic [QB-1:0] quo_ff [0:QB];
   logic          big_ff [0:QB];

   // stage 0: scale numerator, flag quotients of more than QB bits
   always_ff @(posedge clock) begin
      rem_ff[0] <= RW'({num_mag, {FRAC_BITS{1'b0}}});
      den_ff[0] <= den_mag;
      quo_ff[0] <= '0;
      big_ff[0] <= RW'({num_mag, {FRAC_BITS{1'b0}}}) >= (RW'(den_mag) << QB);
   end

   // one compare and subtract per stage, MSB first
   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(den_ff[k]) << (QB - 1 - k);
      assign ge  = rem_ff[k] >= dsh;

      always_ff @(posedge clock) begin
         quo_ff[k+1] <= {quo_ff[k][QB-2:0], ge};
         big_ff[k+1] <= big_ff[k];
      end

      if (k < QB - 1) begin : g_pass
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? (rem_ff[k] - dsh) : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign quo = quo_ff[QB];
   assign big = big_ff[QB];

endmodule
`default_nettype wire

// ===== src/tdg_output.sv =====
// Output stage: applies sign, adds the identity, picks the degenerate path
// and saturates; registers the result strobe. Depends on tdg_pkg.
`default_nettype none
module tdg_output
   import tdg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire side_type                 side,
   input  wire logic [LANES-1:0][QB-1:0] quo,
   input  wire logic [LANES-1:0]         big,
   output logic                          rsp_valid,
   output logic [LANES-1:0][CW-1:0]      grad,
   output logic [AW-1:0]                 area,
   output logic                          degen
);

   logic                     vld_ff;
   logic [LANES-1:0][CW-1:0] grad_ff, grad_in;
   logic [AW-1:0]            area_ff;
   logic                     degen_ff;

   always_comb begin
      logic [SW-1:0] mag;
      logic [SW-1:0] sum;
      logic [SW-1:0] add;
      for (int i = 0; i < LANES; i++) begin
         mag = '0;
         sum = '0;
         // identity on the diagonal lanes (xx, yy)
         add = (i == 0 || i == LANES - 1) ? ONE_Q : '0;
         if (side.degen) begin
            sum = {{(SW-JW){side.disp[i][JW-1]}}, side.disp[i]} + add;
            grad_in[i] = sat_word(sum);
         end else if (big[i]) begin
            grad_in[i] = side.neg[i] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            mag = SW'(quo[i]);
            sum = (side.neg[i] ? -mag : mag) + add;
            grad_in[i] = sat_word(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      grad_ff  <= grad_in;
      area_ff  <= side.area;
      degen_ff <= side.degen;
   end

   assign rsp_valid = vld_ff;
   assign grad      = grad_ff;
   assign area      = area_ff;
   assign degen     = degen_ff;

endmodule
`default_nettype wire

// ===== src/tri3_deformation_gradient.sv =====
// Constant-strain triangle deformation gradient, top level.
// Register stages: 38 (3 front-end counting the input registers, 34 divider,
// 1 output). Throughput: one transaction per cycle; busy is always low and
// results cannot be held off.
// Reset (synchronous, active high) clears all valid bits and sets the
// degenerate threshold to 0. Depends on tdg_pkg and the tdg_* modules.
`default_nettype none
module tri3_deformation_gradient
   import tdg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [CW-1:0] req_node0_x,
   input  wire logic [CW-1:0] req_node0_y,
   input  wire logic [CW-1:0] req_node1_x,
   input  wire logic [CW-1:0] req_node1_y,
   input  wire logic [CW-1:0] req_node2_x,
   input  wire logic [CW-1:0] req_node2_y,
   input  wire logic [CW-1:0] req_node0_disp_x,
   input  wire logic [CW-1:0] req_node0_disp_y,
   input  wire logic [CW-1:0] req_node1_disp_x,
   input  wire logic [CW-1:0] req_node1_disp_y,
   input  wire logic [CW-1:0] req_node2_disp_x,
   input  wire logic [CW-1:0] req_node2_disp_y,
   input  wire logic          csr_write_en,
   input  wire logic [CW-1:0] csr_write_data,
   output logic               rsp_valid,
   output logic [CW-1:0]      rsp_grad_xx,
   output logic [CW-1:0]      rsp_grad_xy,
   output logic [CW-1:0]      rsp_grad_yx,
   output logic [CW-1:0]      rsp_grad_yy,
   output logic [AW-1:0]      rsp_element_area,
   output logic               rsp_degenerate
);

   logic [CW-1:0] thr_ff;
   logic          front_valid;
   front_type     front_data;

   logic [LANES-1:0][QB-1:0]  quo;
   logic [LANES-1:0]          big;
   logic [LANES-1:0][CW-1:0]  grad;

   // side data delayed to line up with the dividers
   side_type         side_ff [0:DIV_LAT-1];
   logic [DIV_LAT-1:0] vld_ff;

   assign busy = 1'b0;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   tdg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .n0x       (req_node0_x),
      .n0y       (req_node0_y),
      .n1x       (req_node1_x),
      .n1y       (req_node1_y),
      .n2x       (req_node2_x),
      .n2y       (req_node2_y),
      .u0x       (req_node0_disp_x),
      .u0y       (req_node0_disp_y),
      .u1x       (req_node1_disp_x),
      .u1y       (req_node1_disp_y),
      .u2x       (req_node2_disp_x),
      .u2y       (req_node2_disp_y),
      .threshold (thr_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // one divider per gradient component
   for (genvar i = 0; i < LANES; i++) begin : g_div
      tdg_divider u_div (
         .clock   (clock),
         .num_mag (front_data.num_mag[i]),
         .den_mag (front_data.det_mag),
         .quo     (quo[i]),
         .big     (big[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_LAT-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= front_data.side;
      for (int k = 1; k < DIV_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   tdg_output u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[DIV_LAT-1]),
      .side      (side_ff[DIV_LAT-1]),
      .quo       (quo),
      .big       (big),
      .rsp_valid (rsp_valid),
      .grad      (grad),
      .area      (rsp_element_area),
      .degen     (rsp_degenerate)
   );

   assign rsp_grad_xx = grad[0];
   assign rsp_grad_xy = grad[1];
   assign rsp_grad_yx = grad[2];
   assign rsp_grad_yy = grad[3];

endmodule
`default_nettype wire
